// ===== rtl/ifdc_pkg.sv =====
// Package with shared constants, codes and types of the information frame deframer.
`default_nettype none

package ifdc_pkg;

    localparam logic [7:0] FLAG_BYTE     = 8'h7E;
    localparam logic [7:0] ESC_BYTE      = 8'h7D;
    localparam logic [7:0] FLAG_SUB_BYTE = 8'h5E;
    localparam logic [7:0] ESC_SUB_BYTE  = 8'h5D;
    localparam logic [7:0] CTRL_SEQ1     = 8'h40;
    localparam logic [7:0] CTRL_SEQ0     = 8'h00;
    localparam logic [7:0] REPLY_ACK     = 8'h05;
    localparam logic [7:0] REPLY_REJ     = 8'h01;
    localparam logic [7:0] ADDR_RESET    = 8'h03;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } kind_t;

    typedef enum logic [4:0] {
        ST_HUNT = 5'b00001,
        ST_FLAG = 5'b00010,
        ST_ADDR = 5'b00100,
        ST_CTRL = 5'b01000,
        ST_DATA = 5'b10000
    } state_t;

    typedef struct packed {
        state_t     state;
        logic       esc_pending;
        logic [7:0] held_byte;
        logic       held_valid;
        logic [7:0] running_xor;
        logic       esc_error;
        logic       expected_seq;
    } dfr_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] byte_val;
        logic       seq_bit;
    } dfr_result_t;

endpackage

`default_nettype wire

// ===== rtl/ifdc_if.sv =====
// Handshake interfaces for the received bytes, the results and the address register write.
`default_nettype none

interface ifdc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ifdc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       seq_bit;

    modport source (output valid, output out_kind, output out_byte, output seq_bit,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input seq_bit,
                  output ready);
endinterface

interface ifdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] address_byte;

    modport source (output valid, output address_byte, input ready);
    modport sink (input valid, input address_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/ifdc_step.sv =====
// Per-byte frame decode: next deframer state and the optional result for one byte.
`default_nettype none

module ifdc_step (
    input  wire ifdc_pkg::dfr_state_t cur,
    input  wire logic [7:0]           rx_byte,
    input  wire logic [7:0]           address_byte,
    output ifdc_pkg::dfr_state_t      nxt,
    output logic                      res_valid,
    output ifdc_pkg::dfr_result_t     res
);
    import ifdc_pkg::*;

    logic [7:0] ctrl_exp;
    state_t     miss_state;

    assign ctrl_exp   = cur.expected_seq ? CTRL_SEQ1 : CTRL_SEQ0;
    assign miss_state = (rx_byte == FLAG_BYTE) ? ST_FLAG : ST_HUNT;

    always_comb
    begin
        logic [7:0] value;
        logic       take;
        logic       good;
        kind_t      kind;
        logic [7:0] byte_val;

        nxt       = cur;
        res_valid = 1'b0;
        value     = rx_byte;
        take      = 1'b0;
        good      = 1'b0;
        kind      = KIND_DATA;
        byte_val  = cur.held_byte;

        unique case (cur.state)
            ST_HUNT:
            begin
                if (rx_byte == FLAG_BYTE)
                begin
                    nxt.state = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                // The address compare wins over the flag test.
                nxt.state = (rx_byte == address_byte) ? ST_ADDR : miss_state;
            end
            ST_ADDR:
            begin
                nxt.state = (rx_byte == ctrl_exp) ? ST_CTRL : miss_state;
            end
            ST_CTRL:
            begin
                if (rx_byte == (ctrl_exp ^ address_byte))
                begin
                    nxt.state       = ST_DATA;
                    nxt.esc_pending = 1'b0;
                    nxt.held_byte   = 8'h00;
                    nxt.held_valid  = 1'b0;
                    nxt.running_xor = 8'h00;
                    nxt.esc_error   = 1'b0;
                end
                else
                begin
                    nxt.state = miss_state;
                end
            end
            ST_DATA:
            begin
                if (rx_byte == FLAG_BYTE)
                begin
                    // Closing flag doubles as the next opening flag.
                    nxt.state       = ST_FLAG;
                    nxt.esc_pending = 1'b0;
                    if (cur.held_valid)
                    begin
                        good = !cur.esc_pending && !cur.esc_error
                               && (cur.held_byte == cur.running_xor);
                        res_valid = 1'b1;
                        if (good)
                        begin
                            nxt.expected_seq = ~cur.expected_seq;
                            kind             = KIND_GOOD;
                            byte_val         = REPLY_ACK;
                        end
                        else
                        begin
                            kind     = KIND_BAD;
                            byte_val = REPLY_REJ;
                        end
                    end
                end
                else if (cur.esc_pending)
                begin
                    nxt.esc_pending = 1'b0;
                    take            = 1'b1;
                    if (rx_byte == FLAG_SUB_BYTE)
                    begin
                        value = FLAG_BYTE;
                    end
                    else if (rx_byte == ESC_SUB_BYTE)
                    begin
                        value = ESC_BYTE;
                    end
                    else
                    begin
                        // A bad escape keeps the byte literally and spoils the frame.
                        nxt.esc_error = 1'b1;
                    end
                end
                else if (rx_byte == ESC_BYTE)
                begin
                    nxt.esc_pending = 1'b1;
                end
                else
                begin
                    take = 1'b1;
                end

                if (take)
                begin
                    nxt.held_byte  = value;
                    nxt.held_valid = 1'b1;
                    if (cur.held_valid)
                    begin
                        nxt.running_xor = cur.running_xor ^ cur.held_byte;
                        res_valid       = 1'b1;
                    end
                end
            end
            default:
            begin
                nxt.state = ST_HUNT;
            end
        endcase

        res.kind     = kind;
        res.byte_val = byte_val;
        res.seq_bit  = nxt.expected_seq;
    end

endmodule

`default_nettype wire

// ===== rtl/info_frame_deframer_checker.sv =====
// Top level of the information frame deframer and checker.
`default_nettype none

// Receives one raw serial byte per transaction on rx and recovers information
// frames: opening flag 0x7E, the address set in the address register (reset
// 0x03), the control byte for the expected sequence (0x40 or 0x00), a header
// check equal to control XOR address, a byte-stuffed payload whose last byte
// is the XOR check of the others, and a closing flag. Payload bytes come out
// as data transactions one byte late, and each frame with a payload ends in
// one acknowledge (0x05, kind good, sequence toggled) or reject (0x01, kind
// bad) transaction. Empty frames and header errors give no transaction. The
// block takes one byte per clock cycle while rx ready is high: a byte is
// registered at acceptance, decoded against the frame state once the output
// register is empty or being emptied, and its result lands in an output
// register. The input register keeps taking bytes while a result waits to
// be taken; only a stalled result with a byte already waiting behind it holds
// rx ready low. The address register is to be written through cfg only while
// the block is idle; the block itself does not enforce this. cfg is always ready.
module info_frame_deframer_checker (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ifdc_rx_if.sink     rx,
    ifdc_res_if.source  result,
    ifdc_cfg_if.sink    cfg
);
    import ifdc_pkg::*;

    // Address register.
    logic [7:0] addr_reg;

    // Input register holding the byte that waits for decode.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Frame state carried from byte to byte.
    dfr_state_t st_reg;
    dfr_state_t st_next;

    // Output register.
    logic        out_valid_reg;
    logic        out_valid_next;
    dfr_result_t out_reg;

    logic        step_valid;
    dfr_result_t step_res;
    logic        advance;

    // The decode stage moves whenever it has a byte and the output register
    // is empty or being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || result.ready);
    assign rx.ready  = !in_valid_reg || advance;
    assign cfg.ready = 1'b1;

    ifdc_step u_step (
        .cur          (st_reg),
        .rx_byte      (in_byte_reg),
        .address_byte (addr_reg),
        .nxt          (st_next),
        .res_valid    (step_valid),
        .res          (step_res)
    );

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = step_valid;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= ADDR_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '{state:        ST_HUNT,
                               esc_pending:  1'b0,
                               held_byte:    8'h00,
                               held_valid:   1'b0,
                               running_xor:  8'h00,
                               esc_error:    1'b0,
                               expected_seq: 1'b1};
        end
        else
        begin
            if (cfg.valid)
            begin
                addr_reg <= cfg.address_byte;
            end
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (advance)
            begin
                st_reg <= st_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
        if (advance && step_valid)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.out_kind = out_reg.kind;
    assign result.out_byte = out_reg.byte_val;
    assign result.seq_bit  = out_reg.seq_bit;

endmodule

`default_nettype wire

// ===== rtl/ifdc_checker.sv =====
// Port-level assertions for the information frame deframer, bound to the top level.
`default_nettype none

module ifdc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rx_valid,
    input wire logic       rx_ready,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_byte,
    input wire logic       seq_bit
);
    import ifdc_pkg::*;

    // A stalled result transaction keeps its payload.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_kind)
                                    && $stable(out_byte) && $stable(seq_bit))
        else $error("result changed while stalled");

    // Kind and reply byte agree, and the kind is a defined code.
    a_reply: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (out_kind == KIND_DATA)
                   || (out_kind == KIND_GOOD && out_byte == REPLY_ACK)
                   || (out_kind == KIND_BAD && out_byte == REPLY_REJ))
        else $error("reply byte does not match result kind");

    // A fresh result is checked against an earlier byte accepted on rx.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("result without an accepted byte two cycles earlier");

endmodule

bind info_frame_deframer_checker ifdc_checker u_ifdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_valid  (rx.valid),
    .rx_ready  (rx.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .out_kind  (result.out_kind),
    .out_byte  (result.out_byte),
    .seq_bit   (result.seq_bit)
);

`default_nettype wire
